### rtl/stx_pkg.sv
// ----------------------------------------------------------------------------
// stx_pkg
// Shared types and constants for the STX/ETX frame receiver.
// ----------------------------------------------------------------------------
package stx_pkg;

    localparam logic [7:0] STX_BYTE   = 8'h02;
    localparam logic [7:0] ETX_BYTE   = 8'h03;
    localparam int         MIN_FRAME  = 9;
    localparam int         LEN_HI_POS = 5;
    localparam int         LEN_LO_POS = 6;
    localparam int         LEN_W      = 7;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd64;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } frame_req_t;

    typedef enum logic [2:0] {
        RP_IDLE  = 3'b001,
        RP_FETCH = 3'b010,
        RP_SHOW  = 3'b100
    } replay_state_t;

endpackage

### rtl/stx_ram.sv
// ----------------------------------------------------------------------------
// stx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/stx_rx_ctrl.sv
// ----------------------------------------------------------------------------
// stx_rx_ctrl
// Start hunting, byte storing, and end-of-frame checks (length, declared
// length, XOR checksum).
// ----------------------------------------------------------------------------
module stx_rx_ctrl #(
    parameter int BUF_BYTES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [7:0]                     rx_byte,
    input  logic [stx_pkg::LEN_W-1:0]      max_len,
    output logic                           wr_en,
    output logic [$clog2(BUF_BYTES)-1:0]   wr_addr,
    output logic [7:0]                     wr_data,
    output stx_pkg::frame_req_t            req
);

    localparam int IDX_W = $clog2(BUF_BYTES);
    localparam int CNT_W = $clog2(BUF_BYTES + 1);

    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       xor_reg, xor_next;
    logic [15:0]      decl_reg, decl_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             ok;

    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb
    begin
        ok = (stx_pkg::LEN_W'(cnt_inc) <= max_len)
          && (cnt_inc >= CNT_W'(stx_pkg::MIN_FRAME))
          && ((decl_reg + 16'(stx_pkg::MIN_FRAME)) == 16'(cnt_inc))
          && (xor_reg == 8'h00);
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        cnt_next      = cnt_reg;
        xor_next      = xor_reg;
        decl_next     = decl_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[IDX_W-1:0];
        wr_data       = rx_byte;
        req.start     = 1'b0;
        req.len       = stx_pkg::LEN_W'(cnt_inc);
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == stx_pkg::STX_BYTE)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = '0;
                    cnt_next      = CNT_W'(1);
                    xor_next      = rx_byte;
                    decl_next     = '0;
                    in_frame_next = 1'b1;
                end
            end
            else
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_reg == CNT_W'(stx_pkg::LEN_HI_POS))
                begin
                    decl_next = {rx_byte, decl_reg[7:0]};
                end
                else if (cnt_reg == CNT_W'(stx_pkg::LEN_LO_POS))
                begin
                    decl_next = {decl_reg[15:8], rx_byte};
                end
                if (rx_byte != stx_pkg::ETX_BYTE)
                begin
                    xor_next = xor_reg ^ rx_byte;
                    if (cnt_inc == CNT_W'(BUF_BYTES))
                    begin
                        in_frame_next = 1'b0;
                        cnt_next      = '0;
                        xor_next      = '0;
                        decl_next     = '0;
                    end
                end
                else
                begin
                    req.start     = ok;
                    in_frame_next = 1'b0;
                    cnt_next      = '0;
                    xor_next      = '0;
                    decl_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            cnt_reg      <= '0;
            xor_reg      <= '0;
            decl_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            cnt_reg      <= cnt_next;
            xor_reg      <= xor_next;
            decl_reg     <= decl_next;
        end
    end

endmodule

### rtl/stx_replay.sv
// ----------------------------------------------------------------------------
// stx_replay
// Sequencer that reads an accepted frame back from the store, one byte per
// request, with the last mark on the end byte.
// ----------------------------------------------------------------------------
module stx_replay #(
    parameter int BUF_BYTES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stx_pkg::frame_req_t           req,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          last,
    output logic [stx_pkg::LEN_W-1:0]     len,
    output logic                          idle,
    output logic                          rd_en,
    output logic [$clog2(BUF_BYTES)-1:0]  rd_addr
);

    localparam int IDX_W = $clog2(BUF_BYTES);

    stx_pkg::replay_state_t          state_reg, state_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [stx_pkg::LEN_W-1:0]       len_reg, len_next;

    assign last      = (stx_pkg::LEN_W'(idx_reg) + stx_pkg::LEN_W'(1)) == len_reg;
    assign len       = len_reg;
    assign idle      = (state_reg == stx_pkg::RP_IDLE);
    assign out_valid = (state_reg == stx_pkg::RP_SHOW);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        unique case (state_reg)
            stx_pkg::RP_IDLE:
            begin
                if (req.start)
                begin
                    len_next   = req.len;
                    idx_next   = '0;
                    state_next = stx_pkg::RP_FETCH;
                end
            end
            stx_pkg::RP_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = stx_pkg::RP_SHOW;
            end
            stx_pkg::RP_SHOW:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = stx_pkg::RP_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = stx_pkg::RP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stx_pkg::RP_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

endmodule

### rtl/stx_etx_frame_receiver.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver
// STX/ETX framed byte receiver with XOR checksum; replays good frames.
// ----------------------------------------------------------------------------
// Receive takes one byte per cycle while in_ready is high. When an end byte
// completes a good frame, in_ready drops and the replay sequencer reads the
// frame back from the single-port-read store: the first byte is fetched in
// the RP_FETCH state, then one byte per cycle while out_ready is high. in_ready
// returns the cycle after the last byte is taken. Bad frames are dropped
// with no stall. The frame length limit (max_len_reg) resets to 64.
module stx_etx_frame_receiver #(
    parameter int BUF_BYTES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [stx_pkg::LEN_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    frame_byte,
    output logic                          last_byte,
    output logic [stx_pkg::LEN_W-1:0]     frame_length
);

    localparam int IDX_W = $clog2(BUF_BYTES);

    logic [stx_pkg::LEN_W-1:0] max_len_reg;
    stx_pkg::frame_req_t       req;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [7:0]                wr_data;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= stx_pkg::MAX_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    assign in_ready = idle;

    stx_rx_ctrl #(
        .BUF_BYTES (BUF_BYTES)
    ) u_rx_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_valid && in_ready),
        .rx_byte (rx_byte),
        .max_len (max_len_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .req     (req)
    );

    stx_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (frame_byte)
    );

    stx_replay #(
        .BUF_BYTES (BUF_BYTES)
    ) u_replay (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .last      (last_byte),
        .len       (frame_length),
        .idle      (idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

endmodule

### rtl/stx_chk.sv
// ----------------------------------------------------------------------------
// stx_chk
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module stx_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [7:0]                frame_byte,
    input logic                      last_byte,
    input logic [stx_pkg::LEN_W-1:0] frame_length
);

    // stalled request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte)
                                    && $stable(last_byte))
        else $error("output request changed while stalled");

    // no input taken during replay
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during replay");

    // frame bytes come back to back until the end byte
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_byte |=> out_valid && $stable(frame_length))
        else $error("frame replay broken before end byte");

    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_length >= stx_pkg::LEN_W'(stx_pkg::MIN_FRAME))
        else $error("short frame emitted");

endmodule

bind stx_etx_frame_receiver stx_chk u_stx_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte),
    .frame_length (frame_length)
);

### tb/tb_stx_etx_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_stx_etx_frame_receiver
// Self-checking bench for the STX/ETX frame receiver with XOR checksum.
// ----------------------------------------------------------------------------
// Builds good and broken frames and sends them as byte requests under random
// idling on both sides. It also sends hunting noise, an overflow run and short
// frames. A scoreboard tracks the receiver state and the capacity setting,
// and predicts the bytes of every accepted frame. Replayed bytes are compared
// in order. Capacity is stepped through 64, 8, 9, 127 and 64 again, each
// written while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_stx_etx_frame_receiver;

    localparam int BUF_BYTES     = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 8;

    typedef enum int { FR_GOOD, FR_BAD_SUM, FR_BAD_LEN } frame_kind_t;

    typedef struct {
        logic [7:0]                data;
        logic                      last;
        logic [stx_pkg::LEN_W-1:0] len;
    } replay_byte_t;

    class frame_replay_board;
        logic [stx_pkg::LEN_W-1:0] capacity;
        bit                        in_frame;
        logic [7:0]                store [BUF_BYTES];
        int                        count;
        logic [7:0]                xsum;
        logic [15:0]               declared;
        replay_byte_t              replay_q [$];
        int                        predicted;
        int                        errors;

        function new();
            capacity  = stx_pkg::MAX_LEN_RST;
            predicted = 0;
            errors    = 0;
            hunt();
        endfunction

        function void hunt();
            in_frame = 1'b0;
            count    = 0;
            xsum     = '0;
            declared = '0;
        endfunction

        function int pending();
            return replay_q.size();
        endfunction

        function void note_request(logic [7:0] b);
            bit           ok;
            int           n;
            replay_byte_t r;
            if (!in_frame)
            begin
                if (b == stx_pkg::STX_BYTE)
                begin
                    store[0] = b;
                    count    = 1;
                    xsum     = b;
                    declared = '0;
                    in_frame = 1'b1;
                end
                return;
            end
            store[count] = b;
            if (count == stx_pkg::LEN_HI_POS)
                declared[15:8] = b;
            else if (count == stx_pkg::LEN_LO_POS)
                declared[7:0] = b;
            count++;
            if (b != stx_pkg::ETX_BYTE)
            begin
                xsum ^= b;
                if (count >= BUF_BYTES)
                    hunt();
                return;
            end
            n  = count;
            ok = (n <= int'(capacity)) && (n >= stx_pkg::MIN_FRAME) &&
                 (int'(declared) + stx_pkg::MIN_FRAME == n) && (xsum == 8'h00);
            hunt();
            if (!ok)
                return;
            for (int i = 0; i < n; i++)
            begin
                r.data = store[i];
                r.last = (i == n - 1);
                r.len  = n[stx_pkg::LEN_W-1:0];
                replay_q.push_back(r);
                predicted++;
            end
        endfunction

        function void check_result(logic [7:0] fb, logic lb,
                                   logic [stx_pkg::LEN_W-1:0] fl);
            replay_byte_t r;
            if (replay_q.size() == 0)
            begin
                $error("unexpected byte: frame_byte %0h last_byte %0b frame_length %0d",
                       fb, lb, fl);
                errors++;
                return;
            end
            r = replay_q.pop_front();
            if (fb !== r.data)
            begin
                $error("frame_byte: expected %0h, actual %0h", r.data, fb);
                errors++;
            end
            if (lb !== r.last)
            begin
                $error("last_byte: expected %0b, actual %0b", r.last, lb);
                errors++;
            end
            if (fl !== r.len)
            begin
                $error("frame_length: expected %0d, actual %0d", r.len, fl);
                errors++;
            end
        endfunction
    endclass

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [stx_pkg::LEN_W-1:0]       cfg_wr_data = '0;
    logic                            in_valid    = 1'b0;
    logic                            in_ready;
    logic [7:0]                      rx_byte     = '0;
    logic                            out_valid;
    logic                            out_ready   = 1'b0;
    logic [7:0]                      frame_byte;
    logic                            last_byte;
    logic [stx_pkg::LEN_W-1:0]       frame_length;

    bit                   tx_quiet = 1'b0;
    bit                   rx_quiet = 1'b0;
    int                   sent     = 0;
    frame_replay_board    board;

    stx_etx_frame_receiver #(
        .BUF_BYTES (BUF_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .frame_length (frame_length)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        out_ready <= rx_quiet || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(frame_byte, last_byte, frame_length);
    end

    function automatic logic [7:0] data_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == stx_pkg::ETX_BYTE);
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(b);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [stx_pkg::LEN_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.capacity = v;
        @(negedge clk);
    endtask

    // pinned puts 0xFF, 0x00 and a start byte into the payload
    task automatic send_frame(input int len, input frame_kind_t kind, input bit pinned);
        logic [7:0]  f [$];
        logic [7:0]  x;
        logic [7:0]  k;
        logic [15:0] dl;
        f  = {};
        dl = 16'(len - stx_pkg::MIN_FRAME);
        f.push_back(stx_pkg::STX_BYTE);
        for (int i = 1; i <= len - 3; i++)
            f.push_back(data_byte());
        f[stx_pkg::LEN_HI_POS] = dl[15:8];
        f[stx_pkg::LEN_LO_POS] = dl[7:0];
        if (pinned)
        begin
            f[2] = 8'hFF;
            f[3] = 8'h00;
            f[4] = stx_pkg::STX_BYTE;
        end
        if (kind == FR_BAD_LEN)
        begin
            do
                f[stx_pkg::LEN_HI_POS] = 8'($urandom_range(1, 255));
            while (f[stx_pkg::LEN_HI_POS] == stx_pkg::ETX_BYTE);
        end
        forever
        begin
            x = '0;
            foreach (f[i])
                x ^= f[i];
            if (x != stx_pkg::ETX_BYTE)
                break;
            f[1] = data_byte();
        end
        if (kind == FR_BAD_SUM)
        begin
            do
                k = 8'($urandom_range(1, 255));
            while ((x ^ k) == stx_pkg::ETX_BYTE);
            x ^= k;
        end
        f.push_back(x);
        f.push_back(stx_pkg::ETX_BYTE);
        foreach (f[i])
            send_byte(f[i]);
    endtask

    task automatic random_traffic(input int byte_goal, input int result_goal);
        int          sent0;
        int          pred0;
        int          len;
        int          pick;
        frame_kind_t kind;
        sent0 = sent;
        pred0 = board.predicted;
        while (sent - sent0 < byte_goal || board.predicted - pred0 < result_goal)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(stx_pkg::MIN_FRAME, BUF_BYTES);
            else
                len = $urandom_range(stx_pkg::MIN_FRAME, 16);
            // a length byte of 0x03 would close the frame early
            if (len == 12)
                len = 13;
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                kind = (pick < 70) ? FR_GOOD : (pick < 85) ? FR_BAD_SUM : FR_BAD_LEN;
                send_frame(len, kind, 1'b0);
            end
            if (pick == 50)
                drain();
        end
    endtask

    initial
    begin
        board = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // noise while hunting, then frames at reset capacity
        send_byte(8'h00);
        send_byte(stx_pkg::ETX_BYTE);
        send_frame(stx_pkg::MIN_FRAME, FR_GOOD, 1'b1);
        send_byte(stx_pkg::STX_BYTE);
        send_byte(stx_pkg::ETX_BYTE);
        send_frame(stx_pkg::MIN_FRAME, FR_BAD_SUM, 1'b0);
        send_frame(10, FR_BAD_LEN, 1'b0);
        drain();

        // buffer fills without an end byte
        send_byte(stx_pkg::STX_BYTE);
        repeat (BUF_BYTES - 1)
            send_byte(data_byte());
        send_byte(8'h41);

        write_capacity(7'd8);
        send_frame(stx_pkg::MIN_FRAME, FR_GOOD, 1'b0);

        write_capacity(7'd9);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_frame(stx_pkg::MIN_FRAME, FR_GOOD, 1'b1);

        write_capacity(7'h7F);
        random_traffic(12, 0);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        write_capacity(stx_pkg::MAX_LEN_RST);

        drain();
        repeat (20) @(negedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(12 * 1000000);
        $display("Mismatches found");
        $finish;
    end

endmodule
